// ===== design/dpmw_pkg.sv =====
// Shared widths, reset values and register codes for the pulse meter window block.
`default_nettype none
package dpmw_pkg;

    localparam int TOTAL_W  = 32;
    localparam int DELTA_W  = 16;
    localparam int TICK_W   = 21;
    localparam int DEB_W    = 20;
    localparam int MULT_W   = 12;
    localparam int FLOW_W   = 28;
    localparam int SUM_W    = 22;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam int IN_DW    = 40;
    localparam int IN_UW    = 1;
    localparam int OUT_DW   = 88;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST = DEB_W'(60000);
    localparam logic [MULT_W-1:0] MULT_RST     = MULT_W'(60);
    localparam logic [TICK_W-1:0] TICK_MAX     = {TICK_W{1'b1}};
    localparam logic [DELTA_W-1:0] DELTA_MAX   = {DELTA_W{1'b1}};

    // Register index, taken from paddr[2]
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_FLOW     = 1'b1;

    typedef logic [DELTA_W-1:0] t_delta;
    typedef logic [TOTAL_W-1:0] t_total;

endpackage
`default_nettype wire

// ===== design/debounced_pulse_meter_window_top.sv =====
// Top level of the debounced pulse meter with interval flow and window sum.
//
// Each input word is one time tick and the block takes one word per clock while
// the result side keeps up. A tick may load the total (tuser), flag a meter
// pulse edge and flag the end of a publish interval; a publish tick yields one
// result word via registers r_pub, r_s2, r_s3 and r_out holding the total, the interval
// delta times the flow multiplier, and the sum of the last WINDOW deltas. The debounce
// counter, pending flag and total update together on each accepted tick, which sets
// the rate of one word per cycle unless stalled; the delta, multiply and window stages
// follow behind it as a short pipeline. The window is a row of WINDOW delta cells that
// shift one place on every publish, the oldest delta leaving the running sum as the
// newest enters. While a result sits in the output register and the sink is not ready,
// the whole pipeline holds and s_axis_tready drops. Reset clears all cells, so
// no clearing pass is needed. Configuration goes through the APB port at byte
// address 0 (debounce ticks) and 4 (flow multiplier); write only while idle.
`default_nettype none
module debounced_pulse_meter_window_top
    import dpmw_pkg::*;
#(
    parameter int WINDOW = 60
)
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // APB configuration
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [APB_AW-1:0]   paddr,
    input  wire  [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    // Tick stream in
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    // [0] pulse_edge, [1] publish_tick, [33:2] load_value, [39:34] zero
    input  wire  [IN_DW-1:0]    s_axis_tdata,
    // [0] load_total
    input  wire  [IN_UW-1:0]    s_axis_tuser,
    // Result stream out
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    // [31:0] total_pulses, [59:32] flow_pulses, [81:60] window_pulses, [87:82] zero
    output logic [OUT_DW-1:0]   m_axis_tdata
);

    // Configuration registers
    logic [DEB_W-1:0]  r_debounce;
    logic [MULT_W-1:0] r_mult;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_mult     <= MULT_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_DEBOUNCE: r_debounce <= pwdata[DEB_W-1:0];
                REG_FLOW:     r_mult     <= pwdata[MULT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DEBOUNCE: prdata = APB_DW'(r_debounce);
            REG_FLOW:     prdata = APB_DW'(r_mult);
            default:      prdata = '0;
        endcase
    end

    // Advance the whole pipeline unless a result waits on a stalled sink
    logic r_out_valid;
    logic w_adv;
    logic w_accept;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_accept      = s_axis_tvalid && w_adv;

    // Stage 1: debounce and total
    logic   w_pub;
    t_total w_total;

    dpmw_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (w_adv),
        .i_accept         (w_accept),
        .i_pulse_edge     (s_axis_tdata[0]),
        .i_publish_tick   (s_axis_tdata[1]),
        .i_load_total     (s_axis_tuser[0]),
        .i_load_value     (s_axis_tdata[TOTAL_W+1:2]),
        .i_debounce_ticks (r_debounce),
        .o_pub            (w_pub),
        .o_total          (w_total)
    );

    // Stage 2: interval delta, saturated
    t_total r_prev;
    logic   r_s2_valid;
    t_total r_s2_total;
    t_delta r_s2_delta;
    t_total w_diff;
    t_delta w_delta;

    assign w_diff  = w_total - r_prev;
    assign w_delta = (|w_diff[TOTAL_W-1:DELTA_W]) ? DELTA_MAX : w_diff[DELTA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_prev     <= '0;
        end else if (w_adv) begin
            r_s2_valid <= w_pub;
            if (w_pub) begin
                r_prev <= w_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_pub) begin
            r_s2_total <= w_total;
            r_s2_delta <= w_delta;
        end
    end

    // Stage 3: flow product and window shift; 16 x 12 bits never exceeds 28 bits
    logic              r_s3_valid;
    t_total            r_s3_total;
    logic [FLOW_W-1:0] r_s3_flow;
    logic [SUM_W-1:0]  w_sum;
    logic              w_shift;

    assign w_shift = w_adv && r_s2_valid;

    dpmw_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_shift),
        .i_delta (r_s2_delta),
        .o_sum   (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_s3_total <= r_s2_total;
            r_s3_flow  <= FLOW_W'(r_s2_delta) * FLOW_W'(r_mult);
        end
    end

    // Output register
    t_total            r_out_total;
    logic [FLOW_W-1:0] r_out_flow;
    logic [SUM_W-1:0]  r_out_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s3_valid) begin
            r_out_total <= r_s3_total;
            r_out_flow  <= r_s3_flow;
            r_out_sum   <= w_sum;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DW - TOTAL_W - FLOW_W - SUM_W){1'b0}},
                            r_out_sum, r_out_flow, r_out_total};

endmodule
`default_nettype wire

// ===== design/dpmw_cell.sv =====
// One cell of the delta shift line: holds one interval delta.
`default_nettype none
module dpmw_cell
    import dpmw_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_shift,
    input  t_delta i_delta,
    output t_delta o_delta
);

    t_delta r_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= '0;
        end else if (i_shift) begin
            r_delta <= i_delta;
        end
    end

    assign o_delta = r_delta;

endmodule
`default_nettype wire

// ===== design/dpmw_debounce.sv =====
// Per-tick pulse debounce and total update.
`default_nettype none
module dpmw_debounce
    import dpmw_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_adv,
    input  wire               i_accept,
    input  wire               i_pulse_edge,
    input  wire               i_publish_tick,
    input  wire               i_load_total,
    input  t_total            i_load_value,
    input  wire [DEB_W-1:0]   i_debounce_ticks,
    output logic              o_pub,
    output t_total            o_total
);

    t_total              r_total;
    logic                r_pending;
    logic [TICK_W-1:0]   r_ticks;
    logic                r_any;
    logic                r_pub;

    t_total              w_total_ld;
    logic [TICK_W-1:0]   w_ticks_inc;
    logic                w_pend;
    logic                w_take;

    always_comb begin
        w_total_ld  = i_load_total ? i_load_value : r_total;
        w_ticks_inc = (r_ticks == TICK_MAX) ? r_ticks : r_ticks + TICK_W'(1);
        w_pend      = r_pending | i_pulse_edge;
        w_take      = w_pend && (!r_any || (w_ticks_inc > {1'b0, i_debounce_ticks}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_pending <= 1'b0;
            r_ticks   <= '0;
            r_any     <= 1'b0;
            r_pub     <= 1'b0;
        end else begin
            if (i_adv) begin
                r_pub <= i_accept && i_publish_tick;
            end
            if (i_accept) begin
                if (w_take) begin
                    r_total   <= w_total_ld + TOTAL_W'(1);
                    r_pending <= 1'b0;
                    r_any     <= 1'b1;
                    r_ticks   <= '0;
                end else begin
                    r_total   <= w_total_ld;
                    r_pending <= w_pend;
                    r_ticks   <= w_ticks_inc;
                end
            end
        end
    end

    assign o_pub   = r_pub;
    assign o_total = r_total;

endmodule
`default_nettype wire

// ===== design/dpmw_window.sv =====
// Chain of delta cells with a running sum over the window.
`default_nettype none
module dpmw_window
    import dpmw_pkg::*;
#(
    parameter int WINDOW = 60
)
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_shift,
    input  t_delta            i_delta,
    output logic [SUM_W-1:0]  o_sum
);

    t_delta            w_tap [WINDOW+1];
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;

    assign w_tap[0] = i_delta;

    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            dpmw_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_shift),
                .i_delta (w_tap[g]),
                .o_delta (w_tap[g+1])
            );
        end
    endgenerate

    // Drop the oldest delta, add the newest
    assign n_sum = r_sum - SUM_W'(w_tap[WINDOW]) + SUM_W'(i_delta);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_shift) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule
`default_nettype wire
